>>> design/utf8_to_utf16_transcoder_core_assert.svh
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder assertion macros
// Small wrappers for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define U8U16_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8u16 same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define U8U16_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8u16 next-cycle check failed");

`endif

>>> design/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Byte class constants, surrogate constants and the decoder result type.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u16_pkg;

    // byte classification masks and tags
    localparam logic [7:0] ASCII_MASK  = 8'h80;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_TAG   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_TAG   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_TAG   = 8'hF0;

    // continuation bytes owed after each lead kind
    localparam logic [1:0] OWED_NONE   = 2'd0;
    localparam logic [1:0] OWED_ONE    = 2'd1;
    localparam logic [1:0] OWED_TWO    = 2'd2;
    localparam logic [1:0] OWED_THREE  = 2'd3;

    localparam int unsigned CP_W       = 21;
    localparam int unsigned UNIT_W     = 16;

    // surrogate construction
    localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
    localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

    // what one decoded byte hands to the output stage
    typedef struct packed {
        logic              has_result;   // at least one result for this byte
        logic              pair;         // two results (surrogate pair)
        logic              unit_present; // results carry code units
        logic              string_end;   // byte was the final one of the string
        logic [UNIT_W-1:0] first_unit;
        logic [UNIT_W-1:0] second_unit;
    } dec_result_t;

endpackage

`default_nettype wire

>>> design/u8u16_decode.sv
// ----------------------------------------------------------------------------
// UTF-8 byte decoder
// Combinational step: one byte plus the pending sequence state gives the
// next state and up to two UTF-16 code units.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u16_decode
    import u8u16_pkg::*;
(
    input  wire logic [7:0]      byte_in,
    input  wire logic            string_end_in,
    input  wire logic [CP_W-1:0] partial_cp,
    input  wire logic [1:0]      bytes_owed,
    output logic      [CP_W-1:0] partial_cp_next,
    output logic      [1:0]      bytes_owed_next,
    output dec_result_t          result
);

    logic [CP_W-1:0]   cp_shift;
    logic [1:0]        owed_dec;
    logic              done;
    logic [CP_W-1:0]   cp_done;
    logic [CP_W-1:0]   cp_off;
    logic              wide;
    logic [UNIT_W-1:0] hi_unit;
    logic [UNIT_W-1:0] lo_unit;

    assign cp_shift = {partial_cp[CP_W-7:0], byte_in[5:0]};
    assign owed_dec = bytes_owed - 2'd1;

    // sequence tracking
    always_comb
    begin
        done            = 1'b0;
        cp_done         = cp_shift;
        partial_cp_next = partial_cp;
        bytes_owed_next = bytes_owed;
        if (bytes_owed != OWED_NONE && (byte_in & CONT_MASK) == CONT_TAG)
        begin
            partial_cp_next = cp_shift;
            bytes_owed_next = owed_dec;
            done            = (owed_dec == OWED_NONE);
        end
        else
        begin
            // new lead; anything pending is discarded
            partial_cp_next = '0;
            bytes_owed_next = OWED_NONE;
            if ((byte_in & ASCII_MASK) == 8'h00)
            begin
                done    = 1'b1;
                cp_done = {{(CP_W-8){1'b0}}, byte_in};
            end
            else if ((byte_in & LEAD2_MASK) == LEAD2_TAG)
            begin
                partial_cp_next = {{(CP_W-5){1'b0}}, byte_in[4:0]};
                bytes_owed_next = OWED_ONE;
            end
            else if ((byte_in & LEAD3_MASK) == LEAD3_TAG)
            begin
                partial_cp_next = {{(CP_W-4){1'b0}}, byte_in[3:0]};
                bytes_owed_next = OWED_TWO;
            end
            else if ((byte_in & LEAD4_MASK) == LEAD4_TAG)
            begin
                partial_cp_next = {{(CP_W-3){1'b0}}, byte_in[2:0]};
                bytes_owed_next = OWED_THREE;
            end
            // stray continuation and F8..FF fall through: dropped
        end
        if (done)
        begin
            partial_cp_next = '0;
        end
        if (string_end_in)
        begin
            partial_cp_next = '0;
            bytes_owed_next = OWED_NONE;
        end
    end

    // surrogate split; high unit wraps to 16 bits
    assign cp_off  = cp_done - SUPP_BASE;
    assign wide    = (cp_done[CP_W-1:UNIT_W] != '0);
    assign hi_unit = HI_SURR + {{(UNIT_W-11){1'b0}}, cp_off[CP_W-1:10]};
    assign lo_unit = LO_SURR | {{(UNIT_W-10){1'b0}}, cp_off[9:0]};

    always_comb
    begin
        result.has_result   = done || string_end_in;
        result.pair         = done && wide;
        result.unit_present = done;
        result.string_end   = string_end_in;
        result.second_unit  = lo_unit;
        if (!done)
        begin
            result.first_unit = '0;
        end
        else if (wide)
        begin
            result.first_unit = hi_unit;
        end
        else
        begin
            result.first_unit = cp_done[UNIT_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> design/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder core
// Byte stream in, UTF-16 code unit stream out, with string end marking.
// ----------------------------------------------------------------------------
// Takes UTF-8 bytes and delivers UTF-16 code units through the input
// register, then decode into the result register. A byte that completes a
// code point above 0xFFFF yields a surrogate pair, which holds the result
// register for two output transfers, so a following byte with a result waits
// behind it; all other bytes sustain one byte per cycle while m_axis_tready
// is high. A two-entry input stage (register plus skid) keeps s_axis_tready
// free of any path from m_axis_tready. Invalid leads and stray continuation
// bytes produce nothing; a final byte that produces no unit gives one result
// with tuser[0] low as the string end marker.
`default_nettype none

module utf8_to_utf16_transcoder_core
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // byte input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  wire logic        s_axis_tlast,   // string_end_in
    // code unit output
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] code_unit
    output logic             m_axis_tlast,   // run_last
    output logic [1:0]       m_axis_tuser    // [0] unit_present, [1] string_end_out
);

    // input stage registers
    logic              in_valid_reg,   in_valid_next;
    logic [7:0]        in_byte_reg,    in_byte_next;
    logic              in_end_reg,     in_end_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [7:0]        skid_byte_reg,  skid_byte_next;
    logic              skid_end_reg,   skid_end_next;

    // decoder state
    logic [CP_W-1:0]   cp_reg,   cp_next;
    logic [1:0]        owed_reg, owed_next;

    // result register
    logic              out_valid_reg,   out_valid_next;
    logic              out_second_reg,  out_second_next;
    logic [UNIT_W-1:0] out_unit_reg,    out_unit_next;
    logic [UNIT_W-1:0] out_unit2_reg,   out_unit2_next;
    logic              out_present_reg, out_present_next;
    logic              out_last_reg,    out_last_next;
    logic              out_end_reg,     out_end_next;

    dec_result_t       dec;
    logic [CP_W-1:0]   dec_cp;
    logic [1:0]        dec_owed;
    logic              in_xfer;
    logic              out_xfer;
    logic              out_free;
    logic              advance;
    logic              main_open;

    u8u16_decode u_decode (
        .byte_in         (in_byte_reg),
        .string_end_in   (in_end_reg),
        .partial_cp      (cp_reg),
        .bytes_owed      (owed_reg),
        .partial_cp_next (dec_cp),
        .bytes_owed_next (dec_owed),
        .result          (dec)
    );

    // handshakes
    assign s_axis_tready = !skid_valid_reg;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = out_valid_reg && m_axis_tready;
    assign out_free      = !out_valid_reg || (m_axis_tready && !out_second_reg);
    assign advance       = in_valid_reg && (!dec.has_result || out_free);
    assign main_open     = !in_valid_reg || advance;

    // input register and skid
    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_byte_next    = in_byte_reg;
        in_end_next     = in_end_reg;
        skid_valid_next = skid_valid_reg;
        skid_byte_next  = skid_byte_reg;
        skid_end_next   = skid_end_reg;
        if (main_open)
        begin
            if (skid_valid_reg)
            begin
                in_valid_next   = 1'b1;
                in_byte_next    = skid_byte_reg;
                in_end_next     = skid_end_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_xfer)
            begin
                in_valid_next = 1'b1;
                in_byte_next  = s_axis_tdata;
                in_end_next   = s_axis_tlast;
            end
            else
            begin
                in_valid_next = 1'b0;
            end
        end
        else if (in_xfer)
        begin
            skid_valid_next = 1'b1;
            skid_byte_next  = s_axis_tdata;
            skid_end_next   = s_axis_tlast;
        end
    end

    // decoder state moves with each byte leaving the input register
    assign cp_next   = advance ? dec_cp   : cp_reg;
    assign owed_next = advance ? dec_owed : owed_reg;

    // result register: load a decoded byte, or step through a pair
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_second_next  = out_second_reg;
        out_unit_next    = out_unit_reg;
        out_unit2_next   = out_unit2_reg;
        out_present_next = out_present_reg;
        out_last_next    = out_last_reg;
        out_end_next     = out_end_reg;
        if (advance && dec.has_result)
        begin
            out_valid_next   = 1'b1;
            out_second_next  = dec.pair;
            out_unit_next    = dec.first_unit;
            out_unit2_next   = dec.second_unit;
            out_present_next = dec.unit_present;
            out_last_next    = !dec.pair;
            out_end_next     = dec.string_end;
        end
        else if (out_xfer)
        begin
            if (out_second_reg)
            begin
                out_second_next = 1'b0;
                out_unit_next   = out_unit2_reg;
                out_last_next   = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_second_reg <= 1'b0;
            cp_reg         <= '0;
            owed_reg       <= OWED_NONE;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            skid_valid_reg <= skid_valid_next;
            out_valid_reg  <= out_valid_next;
            out_second_reg <= out_second_next;
            cp_reg         <= cp_next;
            owed_reg       <= owed_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        in_byte_reg     <= in_byte_next;
        in_end_reg      <= in_end_next;
        skid_byte_reg   <= skid_byte_next;
        skid_end_reg    <= skid_end_next;
        out_unit_reg    <= out_unit_next;
        out_unit2_reg   <= out_unit2_next;
        out_present_reg <= out_present_next;
        out_last_reg    <= out_last_next;
        out_end_reg     <= out_end_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_unit_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = {out_end_reg, out_present_reg};

    // checks
`include "utf8_to_utf16_transcoder_core_assert.svh"

    // a pending second unit only exists behind a valid first unit
    `U8U16_ASSERT_IMPLY(a_second_has_first, clk, rst_n, out_second_reg, out_valid_reg && out_present_reg && !out_last_reg)
    // the high surrogate is always followed by the closing low surrogate
    `U8U16_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_xfer && out_second_reg, m_axis_tvalid && m_axis_tlast && m_axis_tuser[0])
    // the skid entry is only used behind a full input register
    `U8U16_ASSERT_IMPLY(a_skid_behind_main, clk, rst_n, skid_valid_reg, in_valid_reg)
    // a bare marker is a single result closing the string
    `U8U16_ASSERT_IMPLY(a_bare_marker, clk, rst_n, out_valid_reg && !out_present_reg, out_last_reg && out_end_reg && out_unit_reg == '0)

endmodule

`default_nettype wire
